>>> sv/tacc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tacc_pkg
// Shared types, constants and helper functions for the text attribute
// colour converter: palette, colour codes and the per-colour decode.
// ----------------------------------------------------------------------------
package tacc_pkg;

   localparam int unsigned ENTRIES = 16;
   localparam int unsigned IDX_W   = 4;
   localparam int unsigned WORD_W  = 14;
   localparam int unsigned DIST_W  = 10;

   localparam logic [15:0] PALETTE [ENTRIES] = '{
      16'hf000, 16'hf00a, 16'hf0a0, 16'hf0aa, 16'hfa00, 16'hfa0a, 16'hfa50, 16'hfaaa,
      16'hf555, 16'hf55f, 16'hf5f5, 16'hf5ff, 16'hff55, 16'hff5f, 16'hfff5, 16'hffff
   };

   localparam logic [WORD_W-1:0] CODE_ANSI_LIMIT  = 14'h0050;
   localparam logic [WORD_W-1:0] CODE_DEFAULT     = 14'h0050;
   localparam logic [WORD_W-1:0] CODE_TRANSPARENT = 14'h0060;
   localparam logic [WORD_W-1:0] ALPHA_LIMIT      = 14'h0fff;
   localparam logic [6:0]        ANSI_XOR         = 7'h40;
   localparam logic [15:0]       TRANSPARENT_ARGB = 16'h0fff;
   localparam logic [DIST_W-1:0] DIST_INIT        = 10'h3ff;

   localparam logic [IDX_W-1:0] FG_DEFAULT_ENTRY = 4'd7;
   localparam logic [IDX_W-1:0] BG_DEFAULT_ENTRY = 4'd0;

   localparam logic [0:0] CSR_DEFAULT_FG = 1'b0;
   localparam logic [0:0] CSR_DEFAULT_BG = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [IDX_W-1:0]  best;
      logic [DIST_W-1:0] score;
   } lane_type;

   typedef struct packed {
      logic [6:0]  index;
      logic [11:0] rgb12;
      logic [15:0] argb16;
   } colour_type;

   function automatic logic [3:0] abs_diff(logic [3:0] a, logic [3:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [DIST_W-1:0] sq_dist(logic [WORD_W-1:0] word,
                                                  logic [15:0] t);
      logic [3:0] dr, dg, db;
      logic [7:0] sr, sg, sb;
      dr = abs_diff(t[11:8], word[10:7]);
      dg = abs_diff(t[7:4], word[6:3]);
      db = abs_diff({t[3:1], 1'b0}, {word[2:0], 1'b0});
      sr = {4'b0, dr} * {4'b0, dr};
      sg = {4'b0, dg} * {4'b0, dg};
      sb = {4'b0, db} * {4'b0, db};
      return {2'b0, sr} + {2'b0, sg} + {2'b0, sb};
   endfunction

   function automatic lane_type cell_step(lane_type lane, logic [IDX_W-1:0] entry);
      lane_type res;
      logic [DIST_W-1:0] d;
      res = lane;
      d   = sq_dist(lane.word, PALETTE[entry]);
      if (d < lane.score) begin
         res.best  = entry;
         res.score = d;
      end
      return res;
   endfunction

   function automatic colour_type decode(lane_type lane, logic [IDX_W-1:0] def_idx,
                                         logic [IDX_W-1:0] def_entry);
      colour_type res;
      logic [WORD_W-1:0] w;
      w = lane.word;
      priority if (w < CODE_ANSI_LIMIT) begin
         res.index  = w[6:0] ^ ANSI_XOR;
         res.rgb12  = PALETTE[w[3:0]][11:0];
         res.argb16 = PALETTE[w[3:0]];
      end else if (w == CODE_DEFAULT) begin
         res.index  = {3'b0, def_idx};
         res.rgb12  = PALETTE[def_entry][11:0];
         res.argb16 = PALETTE[def_entry];
      end else if (w == CODE_TRANSPARENT) begin
         res.index  = {3'b0, def_idx};
         res.rgb12  = PALETTE[def_entry][11:0];
         res.argb16 = TRANSPARENT_ARGB;
      end else begin
         res.index  = (w < ALPHA_LIMIT) ? {3'b0, def_idx} : {3'b0, lane.best};
         res.rgb12  = {w[10:0], 1'b0};
         res.argb16 = {w[13:10], w[10:0], 1'b0};
      end
      return res;
   endfunction

   function automatic logic [23:0] rgb12_to_24(logic [11:0] v);
      return {v[11:8], v[11:8], v[7:4], v[7:4], v[3:0], v[3:0]};
   endfunction

endpackage

>>> sv/tacc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tacc_cell
// One palette entry of the nearest-colour chain: compares both colours
// of a request against its entry and passes the running best onward.
// ----------------------------------------------------------------------------
module tacc_cell #(
   parameter int unsigned ENTRY = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_in,
   input  tacc_pkg::lane_type fg_in,
   input  tacc_pkg::lane_type bg_in,
   output logic               valid_out,
   output tacc_pkg::lane_type fg_out,
   output tacc_pkg::lane_type bg_out
);

   logic               valid_ff;
   tacc_pkg::lane_type fg_ff, fg_in_next;
   tacc_pkg::lane_type bg_ff, bg_in_next;

   always_comb begin
      fg_in_next = tacc_pkg::cell_step(fg_in, tacc_pkg::IDX_W'(ENTRY));
      bg_in_next = tacc_pkg::cell_step(bg_in, tacc_pkg::IDX_W'(ENTRY));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fg_ff <= fg_in_next;
      bg_ff <= bg_in_next;
   end

   assign valid_out = valid_ff;
   assign fg_out    = fg_ff;
   assign bg_out    = bg_ff;

endmodule

>>> sv/text_attr_colour_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_attr_colour_converter
// Converts a packed character attribute into ANSI palette indices and
// RGB12 / RGB24 / ARGB16 colours for foreground and background.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------
//  request   | start, busy          | req_attr
//  response  | rsp_strobe           | rsp_ansi_*, rsp_rgb12_*, rsp_rgb24_*,
//            |                      | rsp_argb16_*
//  csr       | csr_we               | csr_index, csr_wdata
//
//  One request per cycle; busy stays low.
//  Each request passes through one cell per entry of the 16-entry palette
//  chain and then the output register.
//  Synchronous reset clears the chain valids and the strobe; the default
//  indices return to 7 (foreground) and 0 (background).
//  The receiver cannot stall: each response shows for one cycle.
// ----------------------------------------------------------------------------
module text_attr_colour_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_attr,
   output logic        rsp_strobe,
   output logic [6:0]  rsp_ansi_fg,
   output logic [6:0]  rsp_ansi_bg,
   output logic [7:0]  rsp_ansi_pair,
   output logic [11:0] rsp_rgb12_fg,
   output logic [11:0] rsp_rgb12_bg,
   output logic [23:0] rsp_rgb24_fg,
   output logic [23:0] rsp_rgb24_bg,
   output logic [15:0] rsp_argb16_fg,
   output logic [15:0] rsp_argb16_bg,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_wdata
);

   localparam int unsigned N = tacc_pkg::ENTRIES;

   logic               chain_valid [N+1];
   tacc_pkg::lane_type chain_fg    [N+1];
   tacc_pkg::lane_type chain_bg    [N+1];

   logic [3:0] def_fg_ff;
   logic [3:0] def_bg_ff;

   tacc_pkg::colour_type fg_col, bg_col;

   logic        strobe_ff;
   logic [6:0]  ansi_fg_ff, ansi_bg_ff;
   logic [7:0]  pair_ff;
   logic [11:0] rgb12_fg_ff, rgb12_bg_ff;
   logic [23:0] rgb24_fg_ff, rgb24_bg_ff;
   logic [15:0] argb16_fg_ff, argb16_bg_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         def_fg_ff <= 4'd7;
         def_bg_ff <= 4'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            tacc_pkg::CSR_DEFAULT_FG: def_fg_ff <= csr_wdata;
            tacc_pkg::CSR_DEFAULT_BG: def_bg_ff <= csr_wdata;
            default:                  def_fg_ff <= def_fg_ff;
         endcase
      end
   end

   assign chain_valid[0]    = start & ~busy;
   assign chain_fg[0].word  = req_attr[17:4];
   assign chain_fg[0].best  = '0;
   assign chain_fg[0].score = tacc_pkg::DIST_INIT;
   assign chain_bg[0].word  = req_attr[31:18];
   assign chain_bg[0].best  = '0;
   assign chain_bg[0].score = tacc_pkg::DIST_INIT;

   for (genvar i = 0; i < N; i++) begin : g_cell
      tacc_cell #(
         .ENTRY(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .valid_in (chain_valid[i]),
         .fg_in    (chain_fg[i]),
         .bg_in    (chain_bg[i]),
         .valid_out(chain_valid[i+1]),
         .fg_out   (chain_fg[i+1]),
         .bg_out   (chain_bg[i+1])
      );
   end

   always_comb begin
      fg_col = tacc_pkg::decode(chain_fg[N], def_fg_ff, tacc_pkg::FG_DEFAULT_ENTRY);
      bg_col = tacc_pkg::decode(chain_bg[N], def_bg_ff, tacc_pkg::BG_DEFAULT_ENTRY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= chain_valid[N];
      end
   end

   always_ff @(posedge clock) begin
      ansi_fg_ff   <= fg_col.index;
      ansi_bg_ff   <= bg_col.index;
      pair_ff      <= {1'b0, fg_col.index} | {bg_col.index[3:0], 4'b0};
      rgb12_fg_ff  <= fg_col.rgb12;
      rgb12_bg_ff  <= bg_col.rgb12;
      rgb24_fg_ff  <= tacc_pkg::rgb12_to_24(fg_col.rgb12);
      rgb24_bg_ff  <= tacc_pkg::rgb12_to_24(bg_col.rgb12);
      argb16_fg_ff <= fg_col.argb16;
      argb16_bg_ff <= bg_col.argb16;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_ansi_fg   = ansi_fg_ff;
   assign rsp_ansi_bg   = ansi_bg_ff;
   assign rsp_ansi_pair = pair_ff;
   assign rsp_rgb12_fg  = rgb12_fg_ff;
   assign rsp_rgb12_bg  = rgb12_bg_ff;
   assign rsp_rgb24_fg  = rgb24_fg_ff;
   assign rsp_rgb24_bg  = rgb24_bg_ff;
   assign rsp_argb16_fg = argb16_fg_ff;
   assign rsp_argb16_bg = argb16_bg_ff;

   // every request comes out after the chain plus the output register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##17 rsp_strobe)
      else $error("request did not produce a response after 17 cycles");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 17))
      else $error("response without a matching request");

   // indices are either palette entries or raw codes above 0x3f
   a_fg_index: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_ansi_fg[6] || rsp_ansi_fg[5:4] == 2'b00))
      else $error("foreground index out of range");

   a_bg_index: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_ansi_bg[6] || rsp_ansi_bg[5:4] == 2'b00))
      else $error("background index out of range");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("strobe right after reset");

endmodule

>>> tb/sv/tacc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tacc_result_checker
// Watches the request, response and csr ports of the text attribute colour
// converter. It predicts the colours of every accepted request from its own
// copy of the default indices, queues them, and compares each response
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tacc_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_attr,
   input  logic        rsp_strobe,
   input  logic [6:0]  rsp_ansi_fg,
   input  logic [6:0]  rsp_ansi_bg,
   input  logic [7:0]  rsp_ansi_pair,
   input  logic [11:0] rsp_rgb12_fg,
   input  logic [11:0] rsp_rgb12_bg,
   input  logic [23:0] rsp_rgb24_fg,
   input  logic [23:0] rsp_rgb24_bg,
   input  logic [15:0] rsp_argb16_fg,
   input  logic [15:0] rsp_argb16_bg,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          checked_count
);

   localparam logic [15:0] ANSI_PALETTE [16] = '{
      16'hf000, 16'hf00a, 16'hf0a0, 16'hf0aa, 16'hfa00, 16'hfa0a, 16'hfa50, 16'hfaaa,
      16'hf555, 16'hf55f, 16'hf5f5, 16'hf5ff, 16'hff55, 16'hff5f, 16'hfff5, 16'hffff
   };
   localparam logic [3:0] FG_FALLBACK_ENTRY = 4'd7;
   localparam logic [3:0] BG_FALLBACK_ENTRY = 4'd0;

   typedef struct packed {
      logic [6:0]  ansi_fg;
      logic [6:0]  ansi_bg;
      logic [7:0]  ansi_pair;
      logic [11:0] rgb12_fg;
      logic [11:0] rgb12_bg;
      logic [23:0] rgb24_fg;
      logic [23:0] rgb24_bg;
      logic [15:0] argb16_fg;
      logic [15:0] argb16_bg;
   } cell_colours_type;

   cell_colours_type expected_cells[$];
   logic [3:0]       fg_default_idx;
   logic [3:0]       bg_default_idx;
   int               failures = 0;
   int               checked = 0;

   function automatic logic [6:0] closest_index(logic [13:0] w, logic [3:0] def_idx);
      int         dr, dg, db, d, best_dist;
      logic [3:0] best;
      logic [15:0] t;
      if (w < tacc_pkg::CODE_ANSI_LIMIT)
         return w[6:0] ^ tacc_pkg::ANSI_XOR;
      if (w == tacc_pkg::CODE_DEFAULT || w == tacc_pkg::CODE_TRANSPARENT ||
          w < tacc_pkg::ALPHA_LIMIT)
         return {3'b000, def_idx};
      best      = 4'd0;
      best_dist = 32'h3fff;
      for (int i = 0; i < 16; i++) begin
         t  = ANSI_PALETTE[i];
         dr = int'(t[11:8]) - int'(w[10:7]);
         dg = int'(t[7:4]) - int'(w[6:3]);
         db = int'(t[3:0] & 4'he) - int'({w[2:0], 1'b0});
         d  = dr * dr + dg * dg + db * db;
         if (d < best_dist) begin
            best_dist = d;
            best      = 4'(i);
         end
      end
      return {3'b000, best};
   endfunction

   function automatic logic [11:0] word_rgb12(logic [13:0] w, logic [3:0] entry);
      logic [31:0] v;
      if (w < tacc_pkg::CODE_ANSI_LIMIT)
         return ANSI_PALETTE[w[3:0]][11:0];
      if (w == tacc_pkg::CODE_DEFAULT || w == tacc_pkg::CODE_TRANSPARENT)
         return ANSI_PALETTE[entry][11:0];
      v = {18'b0, w} << 1;
      return v[11:0];
   endfunction

   function automatic logic [15:0] word_argb16(logic [13:0] w, logic [3:0] entry);
      logic [31:0] v;
      if (w < tacc_pkg::CODE_ANSI_LIMIT)
         return ANSI_PALETTE[w[3:0]];
      if (w == tacc_pkg::CODE_DEFAULT)
         return ANSI_PALETTE[entry];
      if (w == tacc_pkg::CODE_TRANSPARENT)
         return 16'h0fff;
      v = ((({18'b0, w}) << 2) & 32'hf000) | ((({18'b0, w}) << 1) & 32'h0fff);
      return v[15:0];
   endfunction

   function automatic logic [23:0] spread_rgb12(logic [11:0] v);
      logic [31:0] r;
      r = (32'(v[11:8]) * 32'h110000) | (32'(v[7:4]) * 32'h001100)
        | (32'(v[3:0]) * 32'h000011);
      return r[23:0];
   endfunction

   function automatic cell_colours_type predict_cell(logic [31:0] attr,
                                                     logic [3:0] fg_def,
                                                     logic [3:0] bg_def);
      cell_colours_type c;
      logic [13:0]      fg_word, bg_word;
      logic [31:0]      pair;
      fg_word     = attr[17:4];
      bg_word     = attr[31:18];
      c.ansi_fg   = closest_index(fg_word, fg_def);
      c.ansi_bg   = closest_index(bg_word, bg_def);
      pair        = {25'b0, c.ansi_fg} | ({25'b0, c.ansi_bg} << 4);
      c.ansi_pair = pair[7:0];
      c.rgb12_fg  = word_rgb12(fg_word, FG_FALLBACK_ENTRY);
      c.rgb12_bg  = word_rgb12(bg_word, BG_FALLBACK_ENTRY);
      c.rgb24_fg  = spread_rgb12(c.rgb12_fg);
      c.rgb24_bg  = spread_rgb12(c.rgb12_bg);
      c.argb16_fg = word_argb16(fg_word, FG_FALLBACK_ENTRY);
      c.argb16_bg = word_argb16(bg_word, BG_FALLBACK_ENTRY);
      return c;
   endfunction

   task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         failures++;
         $display("%0t ns: %s expected %h got %h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      cell_colours_type e;
      if (reset) begin
         fg_default_idx = 4'd7;
         bg_default_idx = 4'd0;
         expected_cells.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_cells.size() == 0) begin
               failures++;
               $display("%0t ns: response with no request outstanding", $time);
            end else begin
               e = expected_cells.pop_front();
               checked++;
               compare_field("ansi_fg", 32'(e.ansi_fg), 32'(rsp_ansi_fg));
               compare_field("ansi_bg", 32'(e.ansi_bg), 32'(rsp_ansi_bg));
               compare_field("ansi_pair", 32'(e.ansi_pair), 32'(rsp_ansi_pair));
               compare_field("rgb12_fg", 32'(e.rgb12_fg), 32'(rsp_rgb12_fg));
               compare_field("rgb12_bg", 32'(e.rgb12_bg), 32'(rsp_rgb12_bg));
               compare_field("rgb24_fg", 32'(e.rgb24_fg), 32'(rsp_rgb24_fg));
               compare_field("rgb24_bg", 32'(e.rgb24_bg), 32'(rsp_rgb24_bg));
               compare_field("argb16_fg", 32'(e.argb16_fg), 32'(rsp_argb16_fg));
               compare_field("argb16_bg", 32'(e.argb16_bg), 32'(rsp_argb16_bg));
            end
         end
         if (start && !busy)
            expected_cells.push_back(predict_cell(req_attr, fg_default_idx,
                                                  bg_default_idx));
         if (csr_we) begin
            case (csr_index)
               tacc_pkg::CSR_DEFAULT_FG: fg_default_idx = csr_wdata;
               tacc_pkg::CSR_DEFAULT_BG: bg_default_idx = csr_wdata;
               default: ;
            endcase
         end
      end
      fail_count    <= failures;
      pending       <= expected_cells.size();
      checked_count <= checked;
   end

endmodule

>>> tb/sv/tb_text_attr_colour_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_attr_colour_converter
// Drives character attributes into the colour converter: a directed set of
// colour codes, boundaries and palette colours, then random attributes over
// several default-index settings and sender idle rates. The checker beside
// the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_text_attr_colour_converter;

   localparam int LATENCY      = 17;
   localparam int PHASE_ITEMS  = 580;
   localparam int DRAIN_CYCLES = 2000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_attr;
   logic        rsp_strobe;
   logic [6:0]  rsp_ansi_fg;
   logic [6:0]  rsp_ansi_bg;
   logic [7:0]  rsp_ansi_pair;
   logic [11:0] rsp_rgb12_fg;
   logic [11:0] rsp_rgb12_bg;
   logic [23:0] rsp_rgb24_fg;
   logic [23:0] rsp_rgb24_bg;
   logic [15:0] rsp_argb16_fg;
   logic [15:0] rsp_argb16_bg;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [3:0]  csr_wdata;

   int fail_count;
   int pending;
   int checked_count;
   int idle_pct;

   text_attr_colour_converter dut (.*);

   tacc_result_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [31:0] pack_attr(logic [13:0] bg, logic [13:0] fg,
                                             logic [3:0] style);
      return {bg, fg, style};
   endfunction

   function automatic logic [13:0] palette_word(logic [15:0] argb);
      return {3'b111, argb[11:8], argb[7:4], argb[3:1]};
   endfunction

   function automatic logic [13:0] random_colour_word();
      int sel;
      sel = $urandom_range(99);
      if (sel < 20)      return 14'h0040 | 14'($urandom_range(15));
      else if (sel < 28) return 14'($urandom_range(14'h004f));
      else if (sel < 33) return tacc_pkg::CODE_DEFAULT;
      else if (sel < 38) return tacc_pkg::CODE_TRANSPARENT;
      else if (sel < 45) return 14'($urandom_range(14'h0ffe, 14'h0051));
      else               return 14'($urandom_range(14'h3fff, 14'h0fff));
   endfunction

   task automatic send_request(logic [31:0] attr);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_attr <= attr;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_defaults(logic [3:0] fg_idx, logic [3:0] bg_idx);
      wait_drained();
      repeat (LATENCY + 1) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= tacc_pkg::CSR_DEFAULT_FG;
      csr_wdata <= fg_idx;
      @(posedge clock);
      csr_index <= tacc_pkg::CSR_DEFAULT_BG;
      csr_wdata <= bg_idx;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random(int pct);
      logic [31:0] attr;
      idle_pct = pct;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n == PHASE_ITEMS / 2)
            wait_drained();
         if ($urandom_range(99) < 15)
            attr = $urandom;
         else
            attr = pack_attr(random_colour_word(), random_colour_word(),
                             4'($urandom_range(15)));
         send_request(attr);
      end
   endtask

   initial begin
      #2_000_000;
      $display("text_attr_colour_converter: mismatch");
      $finish;
   end

   initial begin
      logic [31:0] directed [$];
      int          fails;
      int          waited;

      reset     <= 1'b1;
      start     <= 1'b0;
      req_attr  <= '0;
      csr_we    <= 1'b0;
      csr_index <= tacc_pkg::CSR_DEFAULT_FG;
      csr_wdata <= '0;
      idle_pct  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // codes, boundaries and exact palette colours under the reset defaults
      directed.push_back(32'h0000_0000);
      directed.push_back(32'hffff_ffff);
      directed.push_back(pack_attr(14'h0040, 14'h004f, 4'ha));
      directed.push_back(pack_attr(14'h0000, 14'h003f, 4'h5));
      directed.push_back(pack_attr(14'h004f, 14'h004a, 4'h0));
      directed.push_back(pack_attr(tacc_pkg::CODE_DEFAULT, tacc_pkg::CODE_DEFAULT, 4'hf));
      directed.push_back(pack_attr(tacc_pkg::CODE_TRANSPARENT, tacc_pkg::CODE_TRANSPARENT,
                                   4'h3));
      directed.push_back(pack_attr(tacc_pkg::CODE_DEFAULT, tacc_pkg::CODE_TRANSPARENT,
                                   4'h0));
      directed.push_back(pack_attr(14'h0051, 14'h0ffe, 4'h0));
      directed.push_back(pack_attr(14'h0fff, 14'h0ffe, 4'h0));
      directed.push_back(pack_attr(14'h3fff, 14'h3800, 4'h0));
      directed.push_back(pack_attr({3'b111, 4'h7, 4'h7, 3'h3},
                                   {3'b111, 4'h2, 4'h8, 3'h5}, 4'h0));
      directed.push_back(pack_attr({3'b100, 4'h5, 4'h0, 3'h1},
                                   {3'b010, 4'hd, 4'h2, 3'h7}, 4'h0));
      for (int i = 0; i < 8; i++)
         directed.push_back(pack_attr(palette_word(16'hf000 | 16'(i * 16'h0111)),
                                      palette_word(16'hffff - 16'(i * 16'h0222)),
                                      4'(i)));
      directed.push_back(pack_attr(palette_word(16'hfa50), palette_word(16'hf5ff), 4'h0));
      directed.push_back(pack_attr(palette_word(16'hff5f), palette_word(16'hf0aa), 4'h0));
      foreach (directed[k])
         send_request(directed[k]);

      set_defaults(4'd0, 4'd15);
      run_random(9);
      set_defaults(4'd15, 4'd0);
      run_random(71);
      set_defaults(4'($urandom_range(15)), 4'($urandom_range(15)));
      run_random(0);

      start <= 1'b0;
      waited = 0;
      while (pending != 0 && waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 3) @(posedge clock);
      fails = fail_count + ((pending != 0) ? 1 : 0);
      if (pending != 0)
         $display("%0t ns: %0d responses never arrived", $time, pending);

      $display("Checked %0d responses: colour codes, alpha boundaries, palette colours,",
               checked_count);
      $display("then random attributes at sender idle rates of 9, 71 and 0 percent.");
      if (fails == 0)
         $display("text_attr_colour_converter: match");
      else
         $display("text_attr_colour_converter: mismatch");
      $finish;
   end

endmodule
